// ----- hdl/sbled_pkg.sv -----
`timescale 1ns / 1ps
// Shared types, register indexes and the quarter-wave sine function for the breathing LED block.
package sbled_pkg;

    // Sequencer states of the breathing LED block.
    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV,
        S_ROM,
        S_MUL,
        S_DONE
    } t_state;

    // Configuration register indexes.
    localparam int unsigned CFG_ADDR_W = 2;
    localparam int unsigned CFG_DATA_W = 16;
    typedef logic [CFG_ADDR_W-1:0] t_cfg_addr;
    localparam t_cfg_addr CFG_PERIOD_MS   = 2'd0;
    localparam t_cfg_addr CFG_PEAK_BRIGHT = 2'd1;
    localparam t_cfg_addr CFG_CREST_LIMIT = 2'd2;

    // Register reset values.
    localparam logic [15:0] PERIOD_RESET = 16'd2000;
    localparam logic [7:0]  PEAK_RESET   = 8'd180;
    localparam logic [15:0] LIMIT_RESET  = 16'd0;

    // Odd polynomial coefficients of the sine in Q28.
    localparam longint unsigned SIN_A1 = 64'd421657428;
    localparam longint unsigned SIN_A3 = 64'd173399667;
    localparam longint unsigned SIN_A5 = 64'd21392326;
    localparam longint unsigned SIN_A7 = 64'd1256749;
    localparam longint unsigned SIN_A9 = 64'd43068;

    // Mid level of the Q1.15 wave, which is also the largest magnitude.
    localparam logic [16:0] WAVE_MID = 17'd32768;

    // Quarter-wave sine magnitude in Q1.15 for quarter index q; evaluated at elaboration.
    function automatic logic [15:0] quarter_sine(input int unsigned q, input int unsigned pbits);
        longint unsigned z;
        longint unsigned z2;
        longint unsigned r;
        z  = longint'(q) << (18 - pbits);
        z2 = (z * z) >> 16;
        r  = SIN_A7 - ((z2 * SIN_A9) >> 16);
        r  = SIN_A5 - ((z2 * r) >> 16);
        r  = SIN_A3 - ((z2 * r) >> 16);
        r  = SIN_A1 - ((z2 * r) >> 16);
        r  = (z * r + (64'd1 << 28)) >> 29;
        if (r > 64'd32768) begin
            r = 64'd32768;
        end
        return r[15:0];
    endfunction

endpackage

// ----- hdl/sine_breathing_led_with_crest_count.sv -----
`timescale 1ns / 1ps
// Top level of the sine breathing LED with crest counter.
//
// Each input item carries the millisecond time and a restart flag and yields one result item
// with the LED brightness, the running flag and the finish flag. While the wave runs, a single
// restoring divider working one bit per cycle first reduces the time modulo the period and
// then divides the remainder by the period into a PHASE_BITS phase; the sine table lookup
// (S_ROM), the brightness multiply (S_MUL) and the crest update (S_DONE) follow in that order,
// and the input is ready again only back in S_IDLE. While the wave is stopped, an item without
// the restart flag skips the divider and goes from S_IDLE straight to S_DONE. A result waiting
// in the output register does not keep the block from accepting and working on the next item,
// but that item holds in its last step, with the input not ready, until the waiting result is
// taken. A period of zero behaves as a period of one. With a crest limit of zero the wave runs
// forever and the crest counter stays frozen, apart from being cleared by a restart.
module sine_breathing_led_with_crest_count #(
    parameter int unsigned PHASE_BITS = 10,
    parameter int unsigned TIME_BITS  = 32
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // Configuration write port.
    input  logic                         i_cfg_we,
    input  sbled_pkg::t_cfg_addr         i_cfg_addr,
    input  logic [sbled_pkg::CFG_DATA_W-1:0] i_cfg_wdata,
    // Input items.
    input  logic                         s_axis_tvalid,
    output logic                         s_axis_tready,
    input  logic [31:0]                  s_axis_tdata,  // [31:0] now_ms
    input  logic                         s_axis_tuser,  // [0] restart
    // Result items.
    output logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    output logic [7:0]                   m_axis_tdata,  // [7:0] brightness
    output logic [1:0]                   m_axis_tuser   // [0] active, [1] finished
);
    import sbled_pkg::*;

    localparam int unsigned QSIZE   = 1 << (PHASE_BITS - 2);
    localparam int unsigned STEPS   = TIME_BITS + PHASE_BITS;
    localparam int unsigned STEP_W  = $clog2(STEPS);
    localparam int unsigned IDX_W   = PHASE_BITS - 1;

    // Quarter-wave sine table built at elaboration.
    typedef logic [15:0] t_sine_tab [QSIZE+1];

    function automatic t_sine_tab build_sine_tab();
        t_sine_tab tab;
        for (int unsigned k = 0; k <= QSIZE; k++) begin
            tab[k] = quarter_sine(k, PHASE_BITS);
        end
        return tab;
    endfunction

    localparam t_sine_tab SINE_TAB = build_sine_tab();

    // Configuration registers.
    logic [15:0] r_period;
    logic [7:0]  r_peak;
    logic [15:0] r_limit;

    // Control state.
    t_state      r_state, n_state;
    logic [15:0] r_crest_count;
    logic        r_was_high;
    logic        r_running;
    logic        r_out_valid;
    logic [STEP_W-1:0] r_step;

    // Datapath registers.
    logic [TIME_BITS-1:0]  r_now;
    logic [15:0]           r_part;
    logic [15:0]           r_rem;
    logic [PHASE_BITS-1:0] r_quot;
    logic [15:0]           r_mag;
    logic [1:0]            r_quad;
    logic [24:0]           r_prod;
    logic [7:0]            r_out_data;
    logic [1:0]            r_out_user;

    // Sequencer outputs.
    logic w_accept;
    logic w_div_step;
    logic w_load_out;
    logic w_out_free;

    // Divider step signals.
    logic [15:0] w_divisor;
    logic        w_in_bit;
    logic [16:0] w_trial;
    logic        w_ge;
    logic [16:0] w_diff;
    logic [15:0] n_part;

    // Sine lookup and crest signals.
    logic [PHASE_BITS-3:0] w_q;
    logic [IDX_W-1:0]      w_idx;
    logic [16:0]           w_level;
    logic                  w_high;
    logic [15:0]           w_crest_inc;
    logic                  w_count_edge;
    logic                  w_fire;
    logic [7:0]            w_bright;

    // A zero period acts as a period of one.
    assign w_divisor = (r_period == 16'd0) ? 16'd1 : r_period;

    // Restoring divider step: time bits feed in first, zeros afterward.
    assign w_in_bit = (r_step < STEP_W'(TIME_BITS)) ? r_now[TIME_BITS-1] : 1'b0;
    assign w_trial  = {r_part, w_in_bit};
    assign w_ge     = (w_trial >= {1'b0, w_divisor});
    assign w_diff   = w_trial - {1'b0, w_divisor};
    assign n_part   = w_ge ? w_diff[15:0] : w_trial[15:0];

    // Mirror the quarter index on odd quadrants.
    assign w_q   = r_quot[PHASE_BITS-3:0];
    assign w_idx = r_quot[PHASE_BITS-2] ? (IDX_W'(QSIZE) - {1'b0, w_q}) : {1'b0, w_q};

    // Wave level around the midpoint.
    assign w_level = r_quad[1] ? (WAVE_MID - {1'b0, r_mag}) : (WAVE_MID + {1'b0, r_mag});

    // Crest detection on the remainder of this item.
    assign w_high       = (r_rem != 16'd0) && ({r_rem, 1'b0} < {1'b0, w_divisor});
    assign w_crest_inc  = (r_crest_count == 16'hFFFF) ? r_crest_count : r_crest_count + 16'd1;
    assign w_count_edge = r_running && (r_limit != 16'd0) && w_high && !r_was_high;
    assign w_fire       = w_count_edge && (w_crest_inc >= r_limit);
    assign w_bright     = (r_running && !w_fire) ? r_prod[23:16] : 8'd0;

    assign w_out_free = !r_out_valid || m_axis_tready;

    // Next-state logic of the sequencer.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (s_axis_tvalid) begin
                    n_state = (r_running || s_axis_tuser) ? S_DIV : S_DONE;
                end
            end
            S_DIV: begin
                if (r_step == STEP_W'(STEPS - 1)) begin
                    n_state = S_ROM;
                end
            end
            S_ROM: begin
                n_state = S_MUL;
            end
            S_MUL: begin
                n_state = S_DONE;
            end
            S_DONE: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Output decode of the sequencer.
    always_comb begin
        s_axis_tready = 1'b0;
        w_div_step    = 1'b0;
        w_load_out    = 1'b0;
        unique case (r_state)
            S_IDLE:  s_axis_tready = 1'b1;
            S_DIV:   w_div_step    = 1'b1;
            S_ROM:   ;
            S_MUL:   ;
            S_DONE:  w_load_out    = w_out_free;
            default: ;
        endcase
    end

    assign w_accept = s_axis_tvalid && s_axis_tready;

    // Configuration registers; the user writes only while idle, not enforced by the block.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period <= PERIOD_RESET;
            r_peak   <= PEAK_RESET;
            r_limit  <= LIMIT_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                CFG_PERIOD_MS:   r_period <= i_cfg_wdata[15:0];
                CFG_PEAK_BRIGHT: r_peak   <= i_cfg_wdata[7:0];
                CFG_CREST_LIMIT: r_limit  <= i_cfg_wdata[15:0];
                default:         ;
            endcase
        end
    end

    // Sequencer state, step counter and wave state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_step        <= '0;
            r_crest_count <= 16'd0;
            r_was_high    <= 1'b0;
            r_running     <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_accept) begin
                r_step <= '0;
                if (s_axis_tuser) begin
                    r_crest_count <= 16'd0;
                    r_was_high    <= 1'b0;
                    r_running     <= 1'b1;
                end
            end else if (w_div_step) begin
                r_step <= r_step + STEP_W'(1);
            end
            if (w_load_out && r_running && (r_limit != 16'd0)) begin
                r_was_high <= w_high;
                if (w_count_edge) begin
                    r_crest_count <= w_crest_inc;
                end
                if (w_fire) begin
                    r_running <= 1'b0;
                end
            end
        end
    end

    // Divider, table and multiplier datapath.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_now  <= s_axis_tdata[TIME_BITS-1:0];
            r_part <= 16'd0;
        end else if (w_div_step) begin
            r_now  <= {r_now[TIME_BITS-2:0], 1'b0};
            r_part <= n_part;
            r_quot <= {r_quot[PHASE_BITS-2:0], w_ge};
            if (r_step == STEP_W'(TIME_BITS - 1)) begin
                r_rem <= n_part;
            end
        end
        if (r_state == S_ROM) begin
            r_mag  <= SINE_TAB[w_idx];
            r_quad <= r_quot[PHASE_BITS-1:PHASE_BITS-2];
        end
        if (r_state == S_MUL) begin
            r_prod <= {17'd0, r_peak} * {8'd0, w_level};
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load_out) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load_out) begin
            r_out_data <= w_bright;
            r_out_user <= {w_fire, r_running && !w_fire};
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_user;

endmodule

// ----- hdl/sbled_checker.sv -----
`timescale 1ns / 1ps
// Port-level checker for the breathing LED block and its bind to the top level.
module sbled_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       s_axis_tvalid,
    input logic       s_axis_tready,
    input logic       m_axis_tvalid,
    input logic       m_axis_tready,
    input logic [7:0] m_axis_tdata,
    input logic [1:0] m_axis_tuser
);

    // A finishing item reports the wave as stopped and dark.
    a_finish_dark: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser[1]) |-> (!m_axis_tuser[0] && (m_axis_tdata == 8'd0)))
        else $error("finishing item is not dark and stopped");

    // A stopped wave drives the LED off.
    a_stopped_dark: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tuser[0]) |-> (m_axis_tdata == 8'd0))
        else $error("stopped wave with nonzero brightness");

    // The block works on one item at a time.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("ready right after an accepted item");

    // A stalled result item holds.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=>
            (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))
        else $error("stalled result item changed");

endmodule

bind sine_breathing_led_with_crest_count sbled_checker u_sbled_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
